@@ hdl/assert_macros.svh @@
// Assertion macros shared by the cipher unit RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/pfc_pkg.sv @@
// Types and constants for the Playfair cipher unit.
// No dependencies; imported by every module of the unit.
package pfc_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;

   localparam int LETTER_COUNT = 26;
   localparam int SQUARE_CELLS = 25;
   localparam int SQUARE_SIDE  = 5;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      CMD_KEY_BYTE  = 2'd0,
      CMD_KEY_END   = 2'd1,
      CMD_TEXT_BYTE = 2'd2,
      CMD_TEXT_END  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_KEY_LETTER  = 2'd0,
      OP_KEY_END     = 2'd1,
      OP_TEXT_LETTER = 2'd2,
      OP_TEXT_END    = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      letter_type letter;
   } work_type;

   typedef struct packed {
      logic     square_ready;
      cell_type fill_count;
      logic     busy;
   } back_status_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FILL  = 2'd1,
      BK_PLACE = 2'd2,
      BK_CELL  = 2'd3
   } back_state_type;

endpackage

@@ hdl/pfc_ifs.sv @@
// Valid/ready channel interfaces of the Playfair cipher unit.
// No dependencies; used by the top level, front and back.
interface pfc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   modport source (output valid, cmd, data_byte, input ready);
   modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface pfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_char;
   logic [7:0] second_char;
   logic       has_pair;
   logic       is_last;
   modport source (output valid, first_char, second_char, has_pair, is_last, input ready);
   modport sink (input valid, first_char, second_char, has_pair, is_last, output ready);
endinterface

interface pfc_csr_if;
   logic valid;
   logic ready;
   logic direction;
   modport source (output valid, direction, input ready);
   modport sink (input valid, direction, output ready);
endinterface

@@ hdl/playfair_digraph_cipher_unit.sv @@
// Playfair digraph cipher unit. With no stalls a digraph result word is valid once its request
// word has passed the front register, queue write, place read, square read and output register.
// Back end: a key letter or unpaired text letter is taken in IDLE, a digraph passes PLACE and
// CELL; the key square completion walks the alphabet once, on key end or first text.
// Synchronous reset clears control state and direction; square contents stay unwritten.
`include "assert_macros.svh"
module playfair_digraph_cipher_unit import pfc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   pfc_req_if.sink   req_ch,
   pfc_rsp_if.source rsp_ch,
   pfc_csr_if.sink   csr_ch
);

   logic            direction_ff, direction_in;
   logic            fr_valid;
   work_type        fr_word;
   logic            fr_ready;
   logic            q_valid;
   work_type        q_word;
   logic            q_pop;
   back_status_type bk_status;

   assign csr_ch.ready = 1'b1;
   assign direction_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.direction : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
      end
   end

   pfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .work_valid (fr_valid),
      .work       (fr_word),
      .work_ready (fr_ready)
   );

   pfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_word   (fr_word),
      .in_ready  (fr_ready),
      .out_valid (q_valid),
      .out_word  (q_word),
      .out_pop   (q_pop)
   );

   pfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .direction  (direction_ff),
      .work_valid (q_valid),
      .work       (q_word),
      .work_pop   (q_pop),
      .rsp_ch     (rsp_ch),
      .status     (bk_status)
   );

   `ASSERT_IMPLIES(a_ready_full, clock, reset, bk_status.square_ready,
      bk_status.fill_count == 5'(SQUARE_CELLS), "square ready before all cells filled")
   `ASSERT_NEXT(a_ready_sticks, clock, reset, bk_status.square_ready,
      bk_status.square_ready, "square ready dropped")
   `ASSERT_IMPLIES(a_nopair_last, clock, reset, rsp_ch.valid && !rsp_ch.has_pair,
      rsp_ch.is_last && rsp_ch.first_char == 8'd0 && rsp_ch.second_char == 8'd0,
      "empty result not a clean last word")
   `ASSERT_ALWAYS(a_pair_caps, clock, reset, !rsp_ch.valid || !rsp_ch.has_pair ||
      (rsp_ch.first_char >= ASCII_UPPER_A && rsp_ch.first_char <= ASCII_UPPER_Z &&
       rsp_ch.second_char >= ASCII_UPPER_A && rsp_ch.second_char <= ASCII_UPPER_Z),
      "digraph char not a capital")

endmodule

@@ hdl/pfc_front.sv @@
// Front end: accepts request words, folds bytes to letters, drops non-letters.
// Depends on pfc_pkg and pfc_req_if.
module pfc_front import pfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pfc_req_if.sink  req_ch,
   output logic     work_valid,
   output work_type work,
   input  logic     work_ready
);

   logic     work_valid_ff, work_valid_in;
   work_type work_ff, work_in;
   logic     keep;
   logic     is_letter;
   letter_type folded;

   // {is_letter, letter}; J folds onto I
   function automatic logic [5:0] fold_byte(input logic [7:0] b);
      logic [7:0] off;
      logic       ok;
      letter_type l;
      off = '0;
      ok  = 1'b0;
      if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
         off = b - ASCII_UPPER_A;
         ok  = 1'b1;
      end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
         off = b - ASCII_LOWER_A;
         ok  = 1'b1;
      end
      l = off[4:0];
      if (l == LETTER_J) begin
         l = LETTER_I;
      end
      return {ok, l};
   endfunction

   assign {is_letter, folded} = fold_byte(req_ch.data_byte);
   assign req_ch.ready = !work_valid_ff || work_ready;

   always_comb begin
      work_in = work_ff;
      keep    = 1'b0;
      case (cmd_type'(req_ch.cmd))
         CMD_KEY_BYTE: begin
            keep    = is_letter;
            work_in = '{op: OP_KEY_LETTER, letter: folded};
         end
         CMD_KEY_END: begin
            keep    = 1'b1;
            work_in = '{op: OP_KEY_END, letter: '0};
         end
         CMD_TEXT_BYTE: begin
            keep    = is_letter;
            work_in = '{op: OP_TEXT_LETTER, letter: folded};
         end
         CMD_TEXT_END: begin
            keep    = 1'b1;
            work_in = '{op: OP_TEXT_END, letter: '0};
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      work_valid_in = work_valid_ff && !work_ready;
      if (req_ch.ready) begin
         work_valid_in = req_ch.valid && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         work_ff <= work_in;
      end
   end

   assign work_valid = work_valid_ff;
   assign work       = work_ff;

endmodule

@@ hdl/pfc_queue.sv @@
// Small FIFO of classified words between front and back.
// Depends on pfc_pkg.
module pfc_queue import pfc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_word,
   output logic     in_ready,
   output logic     out_valid,
   output work_type out_word,
   input  logic     out_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           slots [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_word  = slots[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= in_word;
      end
   end

endmodule

@@ hdl/pfc_back.sv @@
// Back end: builds the key square, forms digraphs and applies the cipher rules.
// Depends on pfc_pkg and pfc_rsp_if.
module pfc_back import pfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            direction,
   input  logic            work_valid,
   input  work_type        work,
   output logic            work_pop,
   pfc_rsp_if.source       rsp_ch,
   output back_status_type status
);

   back_state_type state_ff, state_in;
   logic [LETTER_COUNT-1:0] taken_ff, taken_in;
   cell_type   fill_ff, fill_in;
   logic       ready_ff, ready_in;
   letter_type held_letter_ff, held_letter_in;
   logic       held_valid_ff, held_valid_in;
   letter_type prior_letter_ff, prior_letter_in;
   logic       prior_valid_ff, prior_valid_in;
   letter_type walk_ff, walk_in;
   logic       last_ff, last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       has_pair_ff, has_pair_in;
   logic       is_last_ff, is_last_in;

   letter_type sq_mem [SQUARE_CELLS];
   cell_type   place_mem [LETTER_COUNT];

   logic       enter_req;
   logic       enter_ok;
   letter_type enter_letter;
   logic       place_rd_en;
   letter_type place_addr_a, place_addr_b;
   cell_type   place_a_ff, place_b_ff;
   logic       cell_rd_en;
   cell_type   cell_addr_a, cell_addr_b;
   letter_type char_a_ff, char_b_ff;
   logic       out_free;
   logic       same_letter;
   logic [2:0] row_a, col_a, row_b, col_b;

   function automatic logic [2:0] cell_row(input cell_type p);
      logic [2:0] r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] cell_col(input cell_type p, input logic [2:0] r);
      cell_type t;
      t = p - {r, 2'b00} - 5'(r);
      return t[2:0];
   endfunction

   // one place along a row or column, wrapping; dec is the decrypt direction
   function automatic logic [2:0] step5(input logic [2:0] x, input logic dec);
      logic [2:0] y;
      if (dec) begin
         y = (x == 3'd0) ? 3'(SQUARE_SIDE - 1) : x - 3'd1;
      end else begin
         y = (x == 3'(SQUARE_SIDE - 1)) ? 3'd0 : x + 3'd1;
      end
      return y;
   endfunction

   function automatic cell_type cell_index(input logic [2:0] r, input logic [2:0] c);
      return {r, 2'b00} + 5'(r) + 5'(c);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign row_a    = cell_row(place_a_ff);
   assign col_a    = cell_col(place_a_ff, row_a);
   assign row_b    = cell_row(place_b_ff);
   assign col_b    = cell_col(place_b_ff, row_b);

   always_comb begin
      state_in        = state_ff;
      taken_in        = taken_ff;
      fill_in         = fill_ff;
      ready_in        = ready_ff;
      held_letter_in  = held_letter_ff;
      held_valid_in   = held_valid_ff;
      prior_letter_in = prior_letter_ff;
      prior_valid_in  = prior_valid_ff;
      walk_in         = walk_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      first_in        = first_ff;
      second_in       = second_ff;
      has_pair_in     = has_pair_ff;
      is_last_in      = is_last_ff;
      enter_req       = 1'b0;
      enter_letter    = work.letter;
      work_pop        = 1'b0;
      place_rd_en     = 1'b0;
      place_addr_a    = held_letter_ff;
      place_addr_b    = work.letter;
      cell_rd_en      = 1'b0;
      cell_addr_a     = '0;
      cell_addr_b     = '0;
      same_letter     = prior_valid_ff && (prior_letter_ff == work.letter);

      case (state_ff)
         BK_IDLE: begin
            if (work_valid) begin
               case (work.op)
                  OP_KEY_LETTER: begin
                     enter_req = !ready_ff;
                     work_pop  = 1'b1;
                  end
                  OP_KEY_END: begin
                     if (ready_ff) begin
                        work_pop = 1'b1;
                     end else begin
                        walk_in  = '0;
                        state_in = BK_FILL;
                     end
                  end
                  OP_TEXT_LETTER: begin
                     if (!ready_ff) begin
                        walk_in  = '0;
                        state_in = BK_FILL;
                     end else begin
                        work_pop        = 1'b1;
                        prior_letter_in = work.letter;
                        prior_valid_in  = 1'b1;
                        // X goes between two equal clean letters, across pairs too
                        if (same_letter && held_valid_ff) begin
                           place_addr_a   = held_letter_ff;
                           place_addr_b   = LETTER_X;
                           held_letter_in = work.letter;
                           held_valid_in  = 1'b1;
                           place_rd_en    = 1'b1;
                        end else if (same_letter) begin
                           place_addr_a  = LETTER_X;
                           place_addr_b  = work.letter;
                           held_valid_in = 1'b0;
                           place_rd_en   = 1'b1;
                        end else if (held_valid_ff) begin
                           place_addr_a  = held_letter_ff;
                           place_addr_b  = work.letter;
                           held_valid_in = 1'b0;
                           place_rd_en   = 1'b1;
                        end else begin
                           held_letter_in = work.letter;
                           held_valid_in  = 1'b1;
                        end
                        if (place_rd_en) begin
                           last_in  = 1'b0;
                           state_in = BK_PLACE;
                        end
                     end
                  end
                  OP_TEXT_END: begin
                     if (!ready_ff) begin
                        walk_in  = '0;
                        state_in = BK_FILL;
                     end else if (held_valid_ff || out_free) begin
                        work_pop        = 1'b1;
                        held_letter_in  = '0;
                        held_valid_in   = 1'b0;
                        prior_letter_in = '0;
                        prior_valid_in  = 1'b0;
                        if (held_valid_ff) begin
                           place_addr_a = held_letter_ff;
                           place_addr_b = LETTER_X;
                           place_rd_en  = 1'b1;
                           last_in      = 1'b1;
                           state_in     = BK_PLACE;
                        end else begin
                           rsp_valid_in = 1'b1;
                           first_in     = '0;
                           second_in    = '0;
                           has_pair_in  = 1'b0;
                           is_last_in   = 1'b1;
                        end
                     end
                  end
                  default: begin
                     work_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_FILL: begin
            // alphabet walk, one letter a cycle
            enter_req    = 1'b1;
            enter_letter = walk_ff;
            walk_in      = walk_ff + 1'b1;
            if (walk_ff == 5'(LETTER_COUNT - 1)) begin
               ready_in = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_PLACE: begin
            cell_rd_en = 1'b1;
            if (row_a == row_b) begin
               cell_addr_a = cell_index(row_a, step5(col_a, direction));
               cell_addr_b = cell_index(row_b, step5(col_b, direction));
            end else if (col_a == col_b) begin
               cell_addr_a = cell_index(step5(row_a, direction), col_a);
               cell_addr_b = cell_index(step5(row_b, direction), col_b);
            end else begin
               cell_addr_a = cell_index(row_a, col_b);
               cell_addr_b = cell_index(row_b, col_a);
            end
            state_in = BK_CELL;
         end
         BK_CELL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               first_in     = ASCII_UPPER_A + 8'(char_a_ff);
               second_in    = ASCII_UPPER_A + 8'(char_b_ff);
               has_pair_in  = 1'b1;
               is_last_in   = last_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      enter_ok = enter_req && (fill_ff < 5'(SQUARE_CELLS)) && !taken_ff[enter_letter];
      if (enter_ok) begin
         taken_in = taken_ff | (LETTER_COUNT'(1) << enter_letter);
         fill_in  = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         taken_ff        <= LETTER_COUNT'(1) << LETTER_J;
         fill_ff         <= '0;
         ready_ff        <= 1'b0;
         held_letter_ff  <= '0;
         held_valid_ff   <= 1'b0;
         prior_letter_ff <= '0;
         prior_valid_ff  <= 1'b0;
         walk_ff         <= '0;
         last_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         taken_ff        <= taken_in;
         fill_ff         <= fill_in;
         ready_ff        <= ready_in;
         held_letter_ff  <= held_letter_in;
         held_valid_ff   <= held_valid_in;
         prior_letter_ff <= prior_letter_in;
         prior_valid_ff  <= prior_valid_in;
         walk_ff         <= walk_in;
         last_ff         <= last_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      second_ff   <= second_in;
      has_pair_ff <= has_pair_in;
      is_last_ff  <= is_last_in;
   end

   // square and its inverse: one write, two registered reads each
   always_ff @(posedge clock) begin
      if (enter_ok) begin
         sq_mem[fill_ff]         <= enter_letter;
         place_mem[enter_letter] <= fill_ff;
      end
      if (place_rd_en) begin
         place_a_ff <= place_mem[place_addr_a];
         place_b_ff <= place_mem[place_addr_b];
      end
      if (cell_rd_en) begin
         char_a_ff <= sq_mem[cell_addr_a];
         char_b_ff <= sq_mem[cell_addr_b];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.first_char  = first_ff;
   assign rsp_ch.second_char = second_ff;
   assign rsp_ch.has_pair    = has_pair_ff;
   assign rsp_ch.is_last     = is_last_ff;

   assign status.square_ready = ready_ff;
   assign status.fill_count   = fill_ff;
   assign status.busy         = state_ff != BK_IDLE;

endmodule

@@ dv/tb_playfair_digraph_cipher_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for playfair_digraph_cipher_unit: key build, digraph
// encrypt/decrypt, X insertion and text-end padding, against an in-bench predictor.
// Depends on pfc_pkg, the pfc_*_if interfaces and the cipher unit RTL.
module tb_playfair_digraph_cipher_unit;
   import pfc_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int DRAIN_CYCLES    = 64;    // covers pipeline plus the alphabet walk
   localparam int STALL_LIMIT     = 2000;
   localparam int WORDS_PER_PHASE = 70;
   localparam letter_type NO_LETTER = 5'd26;

   typedef struct {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       has_pair;
      logic       is_last;
   } digraph_word_type;

   class playfair_scoreboard;
      letter_type              grid [SQUARE_CELLS];
      logic [4:0]              place [LETTER_COUNT];
      logic [LETTER_COUNT-1:0] taken;
      int                      fill;
      bit                      square_done;
      bit                      held_ok;
      bit                      prior_ok;
      bit                      decrypt;
      letter_type              held;
      letter_type              prior;
      digraph_word_type        expected_q [$];
      int                      mismatches;
      int                      checked;

      function void clear();
         foreach (grid[i]) grid[i] = '0;
         foreach (place[i]) place[i] = '0;
         taken = '0;
         taken[LETTER_J] = 1'b1;
         fill = 0;
         square_done = 0;
         held_ok = 0;
         prior_ok = 0;
         held = '0;
         prior = '0;
         decrypt = 0;
      endfunction

      function letter_type fold(logic [7:0] b);
         letter_type l;
         if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) l = letter_type'(b - ASCII_UPPER_A);
         else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) l = letter_type'(b - ASCII_LOWER_A);
         else return NO_LETTER;
         return (l == LETTER_J) ? LETTER_I : l;
      endfunction

      function void enter(letter_type l);
         if (l >= LETTER_COUNT || fill >= SQUARE_CELLS) return;
         if (taken[l]) return;
         grid[fill] = l;
         place[l] = 5'(fill);
         taken[l] = 1'b1;
         fill++;
      endfunction

      // remaining letters go in alphabetically; J stays out since it starts taken
      function void complete();
         if (square_done) return;
         for (int i = 0; i < LETTER_COUNT; i++) enter(letter_type'(i));
         square_done = 1;
      endfunction

      function logic [7:0] char_at(int r, int c);
         return ASCII_UPPER_A + 8'(grid[(r % SQUARE_SIDE) * SQUARE_SIDE + (c % SQUARE_SIDE)]);
      endfunction

      function digraph_word_type cipher_pair(letter_type a, letter_type b);
         digraph_word_type w;
         int r1, c1, r2, c2, step;
         r1 = int'(place[a]) / SQUARE_SIDE;
         c1 = int'(place[a]) % SQUARE_SIDE;
         r2 = int'(place[b]) / SQUARE_SIDE;
         c2 = int'(place[b]) % SQUARE_SIDE;
         step = decrypt ? SQUARE_SIDE - 1 : 1;
         if (r1 == r2) begin
            w.first_char  = char_at(r1, c1 + step);
            w.second_char = char_at(r2, c2 + step);
         end else if (c1 == c2) begin
            w.first_char  = char_at(r1 + step, c1);
            w.second_char = char_at(r2 + step, c2);
         end else begin
            w.first_char  = char_at(r1, c2);
            w.second_char = char_at(r2, c1);
         end
         w.has_pair = 1'b1;
         w.is_last  = 1'b0;
         return w;
      endfunction

      function void note_word(cmd_type c, logic [7:0] b);
         letter_type       l, a, z;
         bit               got;
         digraph_word_type w;
         got = 0;
         a = '0;
         z = '0;
         case (c)
            CMD_KEY_BYTE: begin
               if (!square_done) enter(fold(b));
            end
            CMD_KEY_END: complete();
            CMD_TEXT_BYTE: begin
               l = fold(b);
               if (l == NO_LETTER) return;
               complete();
               // repeated letter: X goes in between, even across a pair boundary
               if (prior_ok && prior == l) begin
                  if (held_ok) begin
                     a = held;
                     z = LETTER_X;
                     got = 1;
                     held_ok = 0;
                  end else begin
                     held = LETTER_X;
                     held_ok = 1;
                  end
               end
               if (held_ok) begin
                  a = held;
                  z = l;
                  got = 1;
                  held_ok = 0;
               end else begin
                  held = l;
                  held_ok = 1;
               end
               prior = l;
               prior_ok = 1;
               if (got) expected_q.push_back(cipher_pair(a, z));
            end
            default: begin
               complete();
               w = '{8'h00, 8'h00, 1'b0, 1'b0};
               if (held_ok) w = cipher_pair(held, LETTER_X);
               w.is_last = 1'b1;
               held_ok = 0;
               held = '0;
               prior_ok = 0;
               prior = '0;
               expected_q.push_back(w);
            end
         endcase
      endfunction

      task report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
         mismatches++;
         $display("%0t: %s got %0h expected %0h", $time, what, got, exp);
      endtask

      task check_word(digraph_word_type got);
         digraph_word_type exp;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result word, first_char", got.first_char, 8'h00);
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         if (got.first_char !== exp.first_char)
            report_mismatch("first_char", got.first_char, exp.first_char);
         if (got.second_char !== exp.second_char)
            report_mismatch("second_char", got.second_char, exp.second_char);
         if (got.has_pair !== exp.has_pair)
            report_mismatch("has_pair", 8'(got.has_pair), 8'(exp.has_pair));
         if (got.is_last !== exp.is_last)
            report_mismatch("is_last", 8'(got.is_last), 8'(exp.is_last));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   source_idle_pct = 0;
   int   sink_idle_pct = 0;
   int   letters_sent = 0;
   int   messages_sent = 0;
   int   stall_cycles = 0;
   int   source_pct [3] = '{11, 53, 0};
   int   sink_pct [3] = '{53, 11, 0};

   playfair_scoreboard sb = new;

   pfc_req_if req_ch ();
   pfc_rsp_if rsp_ch ();
   pfc_csr_if csr_ch ();

   playfair_digraph_cipher_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // result side: check on handshake, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_word('{rsp_ch.first_char, rsp_ch.second_char, rsp_ch.has_pair, rsp_ch.is_last});
      rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [7:0] letter_byte(int idx);
      return 8'(($urandom_range(0, 1) ? ASCII_LOWER_A : ASCII_UPPER_A) + idx);
   endfunction

   task automatic send_word(cmd_type c, logic [7:0] b);
      while ($urandom_range(0, 99) < source_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= c;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_word(c, b);
      if (c == CMD_TEXT_BYTE && sb.fold(b) != NO_LETTER) letters_sent++;
      if (c == CMD_TEXT_END) messages_sent++;
   endtask

   task automatic write_direction(logic d);
      csr_ch.valid     <= 1'b1;
      csr_ch.direction <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.decrypt = d;
   endtask

   // letters that cause no result may still be in flight after the last result
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      repeat ($urandom_range(0, 3)) send_word(CMD_KEY_BYTE, letter_byte($urandom_range(0, 25)));
      send_word(CMD_KEY_BYTE, 8'h00);
      send_word(CMD_KEY_BYTE, "j");
      send_word(CMD_KEY_BYTE, "Q");
      send_word(CMD_KEY_BYTE, "@");
      send_word(CMD_KEY_BYTE, "z");
      send_word(CMD_KEY_BYTE, "I");
      send_word(CMD_KEY_BYTE, "{");
      send_word(CMD_KEY_BYTE, "A");
      send_word(CMD_KEY_BYTE, 8'hFF);
      // text ahead of key end finishes the square; later key words do nothing
      send_word(CMD_TEXT_BYTE, "h");
      send_word(CMD_KEY_END, 8'h00);
      send_word(CMD_KEY_BYTE, "B");
      send_word(CMD_TEXT_BYTE, "e");
      send_word(CMD_TEXT_BYTE, "l");
      send_word(CMD_TEXT_BYTE, "l");
      send_word(CMD_TEXT_BYTE, "o");
      send_word(CMD_TEXT_BYTE, "x");
      send_word(CMD_TEXT_BYTE, "x");
      send_word(CMD_TEXT_BYTE, 8'h60);
      send_word(CMD_TEXT_END, 8'h00);
      send_word(CMD_TEXT_END, 8'hFF);
      send_word(CMD_TEXT_BYTE, "Z");
      send_word(CMD_TEXT_BYTE, "a");
      send_word(CMD_TEXT_BYTE, "J");
      send_word(CMD_TEXT_BYTE, "i");
      send_word(CMD_TEXT_END, 8'h5B);
   endtask

   task automatic run_messages(int quota);
      int         start;
      int         n;
      int         idx;
      int         pick;
      logic [7:0] b;
      start = letters_sent + messages_sent;
      idx = 0;
      while (letters_sent + messages_sent - start < quota) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 18);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               b = 8'($urandom_range(0, 255));
               send_word(CMD_TEXT_BYTE, b);
            end else if (pick < 9) begin
               send_word(cmd_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
               // keep the same letter now and then to force X insertion
               if (pick >= 30 || i == 0) idx = $urandom_range(0, 25);
               send_word(CMD_TEXT_BYTE, letter_byte(idx));
            end
         end
         send_word(CMD_TEXT_END, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= CMD_KEY_BYTE;
      req_ch.data_byte <= 8'h00;
      csr_ch.valid     <= 1'b0;
      csr_ch.direction <= 1'b0;
      sb.clear();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 3; p++) begin
         source_idle_pct = source_pct[p];
         sink_idle_pct   = sink_pct[p];
         for (int h = 0; h < 2; h++) begin
            wait_idle();
            write_direction(1'((p + h) % 2));
            if (p == 0 && h == 0) run_directed();
            run_messages(WORDS_PER_PHASE);
         end
      end
      wait_idle();
      $display("Sent %0d text letters in %0d messages, encrypt and decrypt, three idle mixes;",
               letters_sent, messages_sent);
      $display("%0d result words compared, %0d field mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
